// File: hdl/readout_stream_hit_histogram_assert.svh
// Assertion macros for the checker of the readout stream hit histogram.
`ifndef READOUT_STREAM_HIT_HISTOGRAM_ASSERT_SVH
`define READOUT_STREAM_HIT_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, off during reset.
`define RSHH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rshh assertion failed: same-cycle implication");

// Next-cycle implication, off during reset.
`define RSHH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rshh assertion failed: next-cycle implication");

// Next-cycle implication that also holds across reset.
`define RSHH_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("rshh assertion failed: next-cycle implication across reset");

`endif

// File: hdl/rshh_pkg.sv
// Package of the readout stream hit histogram: types, codes and constants.
`default_nettype none
package rshh_pkg;

   // Parameter defaults
   localparam int CRATES_DEF          = 16;
   localparam int CARDS_PER_CRATE_DEF = 16;
   localparam int COUNT_WIDTH_DEF     = 16;

   // Fixed geometry and widths
   localparam int CHANNELS   = 16;
   localparam int CSR_WIDTH  = 40;
   localparam int CARD_BITS  = 5;

   // Saturation limits
   localparam logic [4:0]  POS_SAT   = 5'd16;
   localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

   // Register indexes
   localparam logic CSR_CARDS_LOW  = 1'b0;
   localparam logic CSR_CARDS_HIGH = 1'b1;

   // Item function codes
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_BYTE  = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   // Record type codes
   localparam logic [2:0] REC_END     = 3'd0;
   localparam logic [2:0] REC_HIT     = 3'd4;
   localparam logic [2:0] REC_CRATE   = 3'd5;
   localparam logic [2:0] REC_HIT_ROW = 3'd6;
   localparam logic [2:0] REC_ROW     = 3'd7;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data_byte;
      logic [3:0] read_crate;
      logic [3:0] read_card;
      logic [3:0] read_channel;
   } req_type;

   typedef struct packed {
      logic [2:0]  record_type;
      logic [4:0]  current_crate;
      logic [4:0]  current_row;
      logic        hit_rejected;
      logic        stream_ended;
      logic        byte_ignored;
      logic [15:0] row_error_total;
      logic [15:0] unused_total;
      logic [15:0] count_value;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EXEC
   } state_type;

   typedef struct packed {
      logic item_load;
      logic mem_rd;
      logic commit;
      logic clr_step;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic out_free;
      logic is_start;
   } sts_type;

endpackage
`default_nettype wire

// File: hdl/rshh_ctrl.sv
// Controller state machine of the readout stream hit histogram.
`default_nettype none
module rshh_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rshh_pkg::sts_type sts,
   output rshh_pkg::cmd_type      cmd
);

   rshh_pkg::state_type state_ff, state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rshh_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Select next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rshh_pkg::ST_CLEAR: begin
            if (sts.clr_done) state_in = rshh_pkg::ST_IDLE;
         end
         rshh_pkg::ST_IDLE: begin
            if (req_valid) state_in = rshh_pkg::ST_READ;
         end
         rshh_pkg::ST_READ: begin
            state_in = rshh_pkg::ST_EXEC;
         end
         rshh_pkg::ST_EXEC: begin
            if (sts.out_free) begin
               state_in = sts.is_start ? rshh_pkg::ST_CLEAR : rshh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rshh_pkg::ST_CLEAR;
         end
      endcase
   end

   // Drive commands
   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      case (state_ff)
         rshh_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         rshh_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.item_load = req_valid;
         end
         rshh_pkg::ST_READ: begin
            cmd.mem_rd = 1'b1;
         end
         rshh_pkg::ST_EXEC: begin
            cmd.commit = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

// File: hdl/rshh_datapath.sv
// Datapath of the readout stream hit histogram: registers, count memory, decode.
`default_nettype none
module rshh_datapath #(
   parameter int CRATES          = rshh_pkg::CRATES_DEF,
   parameter int CARDS_PER_CRATE = rshh_pkg::CARDS_PER_CRATE_DEF,
   parameter int COUNT_WIDTH     = rshh_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic                             csr_index,
   input  wire logic [rshh_pkg::CSR_WIDTH-1:0]   csr_wdata,
   input  wire rshh_pkg::req_type                req_data,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_valid,
   output rshh_pkg::rsp_type                     rsp_data,
   input  wire rshh_pkg::cmd_type                cmd,
   output rshh_pkg::sts_type                     sts
);

   localparam int DEPTH = CRATES * CARDS_PER_CRATE * rshh_pkg::CHANNELS;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   // Registers
   rshh_pkg::req_type                item_ff;
   logic [rshh_pkg::CSR_WIDTH-1:0]   cards_low_ff, cards_high_ff;
   logic [4:0]                       crate_ff, crate_in;
   logic [4:0]                       row_ff, row_in;
   logic                             ended_ff, ended_in;
   logic [15:0]                      rowerr_ff, rowerr_in;
   logic [15:0]                      unused_ff, unused_in;
   logic [COUNT_WIDTH-1:0]           rd_ff;
   rshh_pkg::rsp_type                rsp_ff, rsp_in;
   logic                             rsp_valid_ff;
   logic [AW-1:0]                    clr_ff;
   logic [COUNT_WIDTH-1:0]           mem [DEPTH];

   // Combinational signals
   logic [4:0]                       sel_crate, sel_row;
   logic [3:0]                       sel_fibre;
   logic [31:0]                      addr_full;
   logic [AW-1:0]                    addr, wr_addr;
   logic [2*rshh_pkg::CSR_WIDTH-1:0] cards_all;
   logic [4:0]                       cards_raw, cards;
   logic                             hit_wr, mem_we;
   logic [COUNT_WIDTH-1:0]           wr_data;
   logic [2:0]                       rtype;
   logic                             rejected, ignored;
   logic [15:0]                      value;

   // Write configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cards_low_ff  <= '0;
         cards_high_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            rshh_pkg::CSR_CARDS_LOW:  cards_low_ff  <= csr_wdata;
            rshh_pkg::CSR_CARDS_HIGH: cards_high_ff <= csr_wdata;
            default:                  cards_low_ff  <= cards_low_ff;
         endcase
      end
   end

   // Capture the accepted word
   always_ff @(posedge clock) begin
      if (cmd.item_load) item_ff <= req_data;
   end

   // Pick the cell: read coordinates or the current hit position
   always_comb begin
      if (item_ff.func == rshh_pkg::FUNC_READ) begin
         sel_crate = {1'b0, item_ff.read_crate};
         sel_row   = {1'b0, item_ff.read_card};
         sel_fibre = item_ff.read_channel;
      end else begin
         sel_crate = crate_ff;
         sel_row   = row_ff;
         sel_fibre = item_ff.data_byte[3:0];
      end
      addr_full = (32'(sel_crate) * 32'(CARDS_PER_CRATE) + 32'(sel_row))
                  * 32'(rshh_pkg::CHANNELS) + 32'(sel_fibre);
      addr      = addr_full[AW-1:0];
   end

   // Look up the card count of the current crate
   always_comb begin
      cards_all = {cards_high_ff, cards_low_ff};
      cards_raw = cards_all[crate_ff[3:0] * rshh_pkg::CARD_BITS +: rshh_pkg::CARD_BITS];
      if (32'(crate_ff) >= 32'(CRATES)) begin
         cards = '0;
      end else if (32'(cards_raw) > 32'(CARDS_PER_CRATE)) begin
         cards = 5'(CARDS_PER_CRATE);
      end else begin
         cards = cards_raw;
      end
   end

   // Decode the word and form the next state
   always_comb begin
      crate_in  = crate_ff;
      row_in    = row_ff;
      ended_in  = ended_ff;
      rowerr_in = rowerr_ff;
      unused_in = unused_ff;
      rtype     = '0;
      rejected  = 1'b0;
      ignored   = 1'b0;
      value     = '0;
      hit_wr    = 1'b0;
      case (item_ff.func)
         rshh_pkg::FUNC_START: begin
            crate_in  = '0;
            row_in    = '0;
            ended_in  = 1'b0;
            rowerr_in = '0;
            unused_in = '0;
         end
         rshh_pkg::FUNC_BYTE: begin
            rtype = item_ff.data_byte[6:4];
            if (ended_ff) begin
               ignored = 1'b1;
               if (unused_ff != rshh_pkg::TOTAL_MAX) unused_in = unused_ff + 16'd1;
            end else begin
               case (rtype)
                  rshh_pkg::REC_END: begin
                     ended_in = 1'b1;
                  end
                  rshh_pkg::REC_HIT, rshh_pkg::REC_HIT_ROW: begin
                     if (row_ff >= cards) begin
                        rejected = 1'b1;
                        if (rowerr_ff != rshh_pkg::TOTAL_MAX) rowerr_in = rowerr_ff + 16'd1;
                     end else begin
                        hit_wr = (rd_ff != CNT_MAX);
                     end
                     if (rtype == rshh_pkg::REC_HIT_ROW && row_ff < rshh_pkg::POS_SAT) begin
                        row_in = row_ff + 5'd1;
                     end
                  end
                  rshh_pkg::REC_CRATE: begin
                     if (crate_ff < rshh_pkg::POS_SAT) crate_in = crate_ff + 5'd1;
                     row_in = '0;
                  end
                  rshh_pkg::REC_ROW: begin
                     if (row_ff < rshh_pkg::POS_SAT) row_in = row_ff + 5'd1;
                  end
                  default: begin
                     row_in = row_ff;
                  end
               endcase
            end
         end
         rshh_pkg::FUNC_READ: begin
            if (32'(item_ff.read_crate) < 32'(CRATES) &&
                32'(item_ff.read_card) < 32'(CARDS_PER_CRATE)) begin
               value = 16'(rd_ff);
            end
         end
         default: begin
            value = '0;
         end
      endcase
      rsp_in.record_type     = rtype;
      rsp_in.current_crate   = crate_in;
      rsp_in.current_row     = row_in;
      rsp_in.hit_rejected    = rejected;
      rsp_in.stream_ended    = ended_in;
      rsp_in.byte_ignored    = ignored;
      rsp_in.row_error_total = rowerr_in;
      rsp_in.unused_total    = unused_in;
      rsp_in.count_value     = value;
   end

   // Commit stream state
   always_ff @(posedge clock) begin
      if (reset) begin
         crate_ff  <= '0;
         row_ff    <= '0;
         ended_ff  <= 1'b0;
         rowerr_ff <= '0;
         unused_ff <= '0;
      end else if (cmd.commit) begin
         crate_ff  <= crate_in;
         row_ff    <= row_in;
         ended_ff  <= ended_in;
         rowerr_ff <= rowerr_in;
         unused_ff <= unused_in;
      end
   end

   // Sweep the count memory after reset and start
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= sts.clr_done ? '0 : clr_ff + 1'b1;
      end
   end

   // Count memory: clear writes, hit increments, registered read
   assign mem_we  = cmd.clr_step | (cmd.commit & hit_wr);
   assign wr_addr = cmd.clr_step ? clr_ff : addr;
   assign wr_data = cmd.clr_step ? '0 : rd_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      if (cmd.mem_rd) rd_ff <= mem[addr];
   end

   // Hold the result word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;
   assign sts.clr_done = (clr_ff == AW'(DEPTH - 1));
   assign sts.out_free = ~rsp_valid_ff | rsp_ready;
   assign sts.is_start = (item_ff.func == rshh_pkg::FUNC_START);

endmodule
`default_nettype wire

// File: hdl/readout_stream_hit_histogram.sv
// rsp_valid rises when the accepted word commits after the read state; the commit
// waits while a result is not yet taken. Each word passes accept, count memory
// read and update/commit before the next is accepted. A start word is followed by a
// sweep of CRATES*CARDS_PER_CRATE*16 cells (4096 by default) taking no word;
// CSR writes land. Synchronous reset clears stream state and CSRs, then sweeps.
`default_nettype none
module readout_stream_hit_histogram #(
   parameter int CRATES          = rshh_pkg::CRATES_DEF,
   parameter int CARDS_PER_CRATE = rshh_pkg::CARDS_PER_CRATE_DEF,
   parameter int COUNT_WIDTH     = rshh_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire rshh_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output rshh_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_we,
   input  wire logic                           csr_index,
   input  wire logic [rshh_pkg::CSR_WIDTH-1:0] csr_wdata
);

   rshh_pkg::cmd_type cmd;
   rshh_pkg::sts_type sts;

   // Sequence each word
   rshh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Decode, count and report
   rshh_datapath #(
      .CRATES          (CRATES),
      .CARDS_PER_CRATE (CARDS_PER_CRATE),
      .COUNT_WIDTH     (COUNT_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
`default_nettype wire

// File: hdl/rshh_checker.sv
// Port-level checker of the readout stream hit histogram and its bind.
`default_nettype none
`include "readout_stream_hit_histogram_assert.svh"
module rshh_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire rshh_pkg::rsp_type rsp_data
);

   // Reset starts the clearing sweep with no result pending
   `RSHH_ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid && !req_ready)

   // A stalled result word holds
   `RSHH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // Position counters saturate
   `RSHH_ASSERT_IMPLY(a_pos_sat, clock, reset, rsp_valid, rsp_data.current_crate <= rshh_pkg::POS_SAT && rsp_data.current_row <= rshh_pkg::POS_SAT)

   // An ignored byte only follows an end record
   `RSHH_ASSERT_IMPLY(a_ignored_ended, clock, reset, rsp_valid && rsp_data.byte_ignored, rsp_data.stream_ended && !rsp_data.hit_rejected)

   // Only hit records are rejected
   `RSHH_ASSERT_IMPLY(a_reject_hit, clock, reset, rsp_valid && rsp_data.hit_rejected, rsp_data.record_type == rshh_pkg::REC_HIT || rsp_data.record_type == rshh_pkg::REC_HIT_ROW)

endmodule

bind readout_stream_hit_histogram rshh_checker u_rshh_checker (.*);
`default_nettype wire
